// ----- hdl/iphc_pkg.sv -----
// Shared types and constants for the in-place patch header check.
// Used by iphc_decode and by the top level inplace_patch_header_check.
`default_nettype none
package iphc_pkg;

    localparam int unsigned DEFAULT_PAGE_BYTES = 4096;
    localparam int unsigned CFG_INDEX_W        = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_PAYLOAD_LENGTH      = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_BODY_LENGTH    = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_IMAGE_SIZE = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCRATCH_BYTES       = 8'd3;

    localparam logic [7:0]  PATCH_TYPE_MASK = 8'h07;
    localparam logic [2:0]  PATCH_TYPE      = 3'd1;
    localparam logic [7:0]  FIRST_VALUE_MASK = 8'h3F;
    localparam logic [7:0]  NEXT_VALUE_MASK  = 8'h7F;
    localparam logic [7:0]  MORE_FLAG        = 8'h80;
    localparam logic [31:0] SIGNED_MAX       = 32'h7FFF_FFFF;
    localparam logic [31:0] TRAILER_BYTES    = 32'd56;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_SHORT     = 4'd1,
        ST_WRONG     = 4'd2,
        ST_TRUNC     = 4'd3,
        ST_OVERFLOW  = 4'd4,
        ST_RANGE     = 4'd5,
        ST_GEOMETRY  = 4'd6,
        ST_FROM      = 4'd7,
        ST_TO        = 4'd8
    } t_status;

    typedef struct packed {
        logic [31:0] payload_length;
        logic [31:0] base_body_length;
        logic [31:0] expected_image_size;
        logic [31:0] scratch_bytes;
    } t_cfg;

    typedef struct packed {
        t_status     status;
        logic [30:0] memory_size;
        logic [30:0] target_size;
    } t_verdict;

endpackage
`default_nettype wire

// ----- hdl/iphc_decode.sv -----
// Header state and per-byte decode of the patch header: varints and verdict.
// Depends on iphc_pkg for the configuration and verdict types.
`default_nettype none
module iphc_decode
    import iphc_pkg::*;
#(
    parameter int unsigned PAGE_BYTES = DEFAULT_PAGE_BYTES
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_patch_byte,
    input  wire logic       i_first_byte,
    input  wire t_cfg       i_cfg,
    output logic            o_emit,
    output t_verdict        o_verdict
);

    localparam int unsigned PAGE_L  = $clog2(PAGE_BYTES);
    localparam int unsigned RECIP_S = 32 + PAGE_L;
    localparam logic [32:0] RECIP   =
        33'(((64'd1 << RECIP_S) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES));
    localparam logic [31:0] PAGE_W  = 32'(PAGE_BYTES);

    logic [2:0]  r_field, n_field;
    logic [31:0] r_count, n_count;
    logic [31:0] r_acc, n_acc;
    logic [5:0]  r_pos, n_pos;
    logic [31:0] r_mem, n_mem;
    logic [31:0] r_seg, n_seg;
    logic [31:0] r_shift, n_shift;
    logic [31:0] r_from, n_from;
    logic        r_verdict, n_verdict;
    logic [31:0] r_quot;

    logic [64:0] quot_prod;
    logic [48:0] back_prod;
    logic [38:0] wide;
    logic [31:0] acc_v;
    logic [5:0]  pos_v;
    logic        ovf;
    logic [32:0] from_sum;
    logic        bad_geom;
    logic        bad_from;
    logic        bad_to;
    t_status     status;

    // The shift quotient by the page size is registered from the
    // stored shift; two more bytes always arrive before it is needed.
    assign quot_prod = 65'(r_shift) * 65'(RECIP);
    assign back_prod = 49'(r_quot) * 49'(PAGE_BYTES);

    assign wide = 39'(i_patch_byte & NEXT_VALUE_MASK) << r_pos[4:0];

    always_comb begin
        if (r_pos == 6'd0) begin
            acc_v = 32'(i_patch_byte & FIRST_VALUE_MASK);
            pos_v = 6'd6;
            ovf   = 1'b0;
        end else begin
            acc_v = r_acc | wide[31:0];
            pos_v = r_pos + 6'd7;
            ovf   = r_pos[5] || (wide[38:32] != 7'd0);
        end
    end

    assign from_sum = 33'(i_cfg.base_body_length) + 33'(TRAILER_BYTES);
    assign bad_geom = (r_mem == 32'd0) || (r_mem > i_cfg.scratch_bytes) ||
                      (r_seg != PAGE_W) || (r_shift > r_mem) ||
                      (back_prod[31:0] != r_shift) ||
                      (r_from > (r_mem - r_shift)) || (acc_v > r_mem);
    assign bad_from = from_sum[32] || (r_from != from_sum[31:0]);
    assign bad_to   = (acc_v != i_cfg.expected_image_size) ||
                      (acc_v > i_cfg.scratch_bytes);

    always_comb begin
        n_field   = r_field;
        n_count   = r_count;
        n_acc     = r_acc;
        n_pos     = r_pos;
        n_mem     = r_mem;
        n_seg     = r_seg;
        n_shift   = r_shift;
        n_from    = r_from;
        n_verdict = r_verdict;
        o_emit    = 1'b0;
        status    = ST_OK;
        if (i_first_byte) begin
            n_field   = 3'd0;
            n_acc     = 32'd0;
            n_pos     = 6'd0;
            n_mem     = 32'd0;
            n_seg     = 32'd0;
            n_shift   = 32'd0;
            n_from    = 32'd0;
            n_verdict = 1'b0;
            n_count   = 32'd1;
            if (i_cfg.payload_length < 32'd2) begin
                o_emit = 1'b1;
                status = ST_SHORT;
            end else if ((i_patch_byte[6:4] & PATCH_TYPE_MASK[2:0]) != PATCH_TYPE) begin
                o_emit = 1'b1;
                status = ST_WRONG;
            end
        end else if (!r_verdict) begin
            if (r_count >= i_cfg.payload_length) begin
                o_emit = 1'b1;
                status = ST_TRUNC;
            end else begin
                n_count = r_count + 32'd1;
                if (ovf) begin
                    o_emit = 1'b1;
                    status = ST_OVERFLOW;
                end else begin
                    n_acc = acc_v;
                    n_pos = pos_v;
                    if ((i_patch_byte & MORE_FLAG) == 8'd0) begin
                        if (acc_v > SIGNED_MAX) begin
                            o_emit = 1'b1;
                            status = ST_RANGE;
                        end else begin
                            n_acc   = 32'd0;
                            n_pos   = 6'd0;
                            n_field = r_field + 3'd1;
                            case (r_field)
                                3'd0: n_mem   = acc_v;
                                3'd1: n_seg   = acc_v;
                                3'd2: n_shift = acc_v;
                                3'd3: n_from  = acc_v;
                                default: begin
                                    o_emit = 1'b1;
                                    if (bad_geom) begin
                                        status = ST_GEOMETRY;
                                    end else if (bad_from) begin
                                        status = ST_FROM;
                                    end else if (bad_to) begin
                                        status = ST_TO;
                                    end else begin
                                        status = ST_OK;
                                    end
                                end
                            endcase
                        end
                    end
                end
            end
        end
        if (o_emit) begin
            n_verdict = 1'b1;
        end
    end

    always_comb begin
        o_verdict.status = status;
        if (status == ST_OK) begin
            o_verdict.memory_size = r_mem[30:0];
            o_verdict.target_size = acc_v[30:0];
        end else begin
            o_verdict.memory_size = 31'd0;
            o_verdict.target_size = 31'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot <= 32'(quot_prod >> RECIP_S);
        if (!i_rst_n) begin
            r_field   <= 3'd0;
            r_count   <= 32'd0;
            r_acc     <= 32'd0;
            r_pos     <= 6'd0;
            r_mem     <= 32'd0;
            r_seg     <= 32'd0;
            r_shift   <= 32'd0;
            r_from    <= 32'd0;
            r_verdict <= 1'b1;
        end else if (i_step) begin
            r_field   <= n_field;
            r_count   <= n_count;
            r_acc     <= n_acc;
            r_pos     <= n_pos;
            r_mem     <= n_mem;
            r_seg     <= n_seg;
            r_shift   <= n_shift;
            r_from    <= n_from;
            r_verdict <= n_verdict;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/inplace_patch_header_check.sv -----
// In-place patch header check, top level.
// Patch bytes enter on the input channel, one item per byte; i_first_byte
// marks byte 0 and restarts the check at any time. A byte accepted while
// no header is in progress is dropped without a result.
// Each header gives at most one verdict item: status, memory size and
// target size, the sizes being zero unless the status is ok.
// One byte is accepted per cycle while o_in_stall is low. A byte passes an
// input register, then the decode logic, and its verdict, if any, is
// registered in the output register when the byte steps the decode.
// The input side has a one-item skid register, so o_in_stall is registered
// and rises only after a byte was taken into the skid register while the
// output was stalled; while i_out_stall holds a valid verdict, later bytes wait.
// Configuration registers are written through i_cfg_valid/o_cfg_ready,
// which is always ready; the user must make writes only while no header is
// in progress, the block itself does not enforce this. Unknown register indexes are ignored.
// After reset all configuration registers hold zero, no header is in progress and both
// channels are empty.
`default_nettype none
module inplace_patch_header_check
    import iphc_pkg::*;
#(
    parameter int unsigned PAGE_BYTES = DEFAULT_PAGE_BYTES
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [7:0]             i_patch_byte,
    input  wire logic                   i_first_byte,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [3:0]                  o_status,
    output logic [30:0]                 o_memory_size,
    output logic [30:0]                 o_target_size,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [31:0]            i_cfg_data
);

    t_cfg       r_cfg;
    logic       r_skid_valid;
    logic [7:0] r_skid_byte;
    logic       r_skid_first;
    logic       r_a_valid;
    logic [7:0] r_a_byte;
    logic       r_a_first;
    logic       r_out_valid;
    t_verdict   r_out;

    logic       accept;
    logic       advance;
    logic       a_free;
    logic       emit;
    t_verdict   verdict;

    assign o_in_stall  = r_skid_valid;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && !r_skid_valid;
    assign advance     = r_a_valid && (!r_out_valid || !i_out_stall);
    assign a_free      = !r_a_valid || advance;

    iphc_decode #(
        .PAGE_BYTES(PAGE_BYTES)
    ) u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_patch_byte (r_a_byte),
        .i_first_byte (r_a_first),
        .i_cfg        (r_cfg),
        .o_emit       (emit),
        .o_verdict    (verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg        <= '0;
            r_skid_valid <= 1'b0;
            r_a_valid    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_PAYLOAD_LENGTH:      r_cfg.payload_length      <= i_cfg_data;
                    CFG_BASE_BODY_LENGTH:    r_cfg.base_body_length    <= i_cfg_data;
                    CFG_EXPECTED_IMAGE_SIZE: r_cfg.expected_image_size <= i_cfg_data;
                    CFG_SCRATCH_BYTES:       r_cfg.scratch_bytes       <= i_cfg_data;
                    default: ;
                endcase
            end
            if (a_free) begin
                if (r_skid_valid) begin
                    r_a_valid    <= 1'b1;
                    r_a_byte     <= r_skid_byte;
                    r_a_first    <= r_skid_first;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_a_valid <= accept;
                    r_a_byte  <= i_patch_byte;
                    r_a_first <= i_first_byte;
                end
            end else if (accept) begin
                r_skid_valid <= 1'b1;
                r_skid_byte  <= i_patch_byte;
                r_skid_first <= i_first_byte;
            end
            if (advance && emit) begin
                r_out_valid <= 1'b1;
                r_out       <= verdict;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out.status;
    assign o_memory_size = r_out.memory_size;
    assign o_target_size = r_out.target_size;

endmodule
`default_nettype wire
